>>> src/cud_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and microcode addresses for the CPU utilisation block.
package cud_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CTR_W         = 64;
    localparam int NUM_CTR       = 8;
    localparam int IDX_W         = $clog2(NUM_CTR);
    localparam int PC_W          = 5;

    localparam int IDX_USER   = 0;
    localparam int IDX_SYSTEM = 2;
    localparam int IDX_IDLE   = 3;
    localparam int IDX_IOWAIT = 4;

    localparam logic [PC_W-1:0] PC_WAIT     = 5'd0;
    localparam logic [PC_W-1:0] PC_CLR      = 5'd1;
    localparam logic [PC_W-1:0] PC_ACC      = 5'd2;
    localparam logic [PC_W-1:0] PC_TOT      = 5'd3;
    localparam logic [PC_W-1:0] PC_IDLE     = 5'd4;
    localparam logic [PC_W-1:0] PC_IDEL     = 5'd5;
    localparam logic [PC_W-1:0] PC_CHK_PREV = 5'd6;
    localparam logic [PC_W-1:0] PC_CHK_BAD  = 5'd7;
    localparam logic [PC_W-1:0] PC_CHK_ZERO = 5'd8;
    localparam logic [PC_W-1:0] PC_DIV      = 5'd9;
    localparam logic [PC_W-1:0] PC_DIV_END  = 5'd24;
    localparam logic [PC_W-1:0] PC_OK       = 5'd25;
    localparam logic [PC_W-1:0] PC_FIRST    = 5'd26;
    localparam logic [PC_W-1:0] PC_BACK     = 5'd27;
    localparam logic [PC_W-1:0] PC_NOTICK   = 5'd28;
    localparam logic [PC_W-1:0] PC_EMIT     = 5'd29;
    localparam logic [PC_W-1:0] PC_RET      = 5'd30;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT,
        OP_CLR,
        OP_ACC,
        OP_TOT,
        OP_IDLE,
        OP_IDEL,
        OP_DLOAD,
        OP_DSAT,
        OP_DSTEP,
        OP_DSTORE,
        OP_COMMIT,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NOVALID,
        C_SUMLOOP,
        C_DIVLOOP,
        C_NOPREV,
        C_BAD,
        C_ZERO,
        C_OUTBUSY
    } t_cond;

    typedef enum logic [1:0] {
        SEL_BUSY,
        SEL_USER,
        SEL_SYS,
        SEL_IOW
    } t_sel;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FIRST,
        ST_BACK,
        ST_NOTICK
    } t_status;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        t_sel            sel;
        t_status         status;
        logic [PC_W-1:0] target;
    } t_cw;

    typedef struct packed {
        logic in_valid;
        logic have_prev;
        logic bad;
        logic zero;
        logic sum_last;
        logic div_last;
        logic out_busy;
    } t_flags;

endpackage

>>> src/cud_sequencer.sv
`timescale 1ns / 1ps
// Microcode ROM, step counter and conditional jump logic.
module cud_sequencer import cud_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_cw    o_cw
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic            take;

    function automatic t_cw ucode(input logic [PC_W-1:0] a);
        t_cw             w;
        logic [PC_W-1:0] k;
        w = '{op: OP_NOP, cond: C_ALWAYS, sel: SEL_BUSY, status: ST_OK, target: PC_WAIT};
        k = a - PC_DIV;
        case (a) inside
            PC_WAIT: begin
                w.op = OP_WAIT;
                w.cond = C_NOVALID;
                w.target = PC_WAIT;
            end
            PC_CLR: begin
                w.op = OP_CLR;
                w.cond = C_NEXT;
            end
            PC_ACC: begin
                w.op = OP_ACC;
                w.cond = C_SUMLOOP;
                w.target = PC_ACC;
            end
            PC_TOT: begin
                w.op = OP_TOT;
                w.cond = C_NEXT;
            end
            PC_IDLE: begin
                w.op = OP_IDLE;
                w.cond = C_NEXT;
            end
            PC_IDEL: begin
                w.op = OP_IDEL;
                w.cond = C_NEXT;
            end
            PC_CHK_PREV: begin
                w.cond = C_NOPREV;
                w.target = PC_FIRST;
            end
            PC_CHK_BAD: begin
                w.cond = C_BAD;
                w.target = PC_BACK;
            end
            PC_CHK_ZERO: begin
                w.cond = C_ZERO;
                w.target = PC_NOTICK;
            end
            [PC_DIV:PC_DIV_END]: begin
                w.sel = t_sel'(k[3:2]);
                w.cond = C_NEXT;
                case (k[1:0])
                    2'd0: w.op = OP_DLOAD;
                    2'd1: w.op = OP_DSAT;
                    2'd2: begin
                        w.op = OP_DSTEP;
                        w.cond = C_DIVLOOP;
                        w.target = a;
                    end
                    default: w.op = OP_DSTORE;
                endcase
            end
            PC_OK: begin
                w.op = OP_COMMIT;
                w.status = ST_OK;
                w.target = PC_EMIT;
            end
            PC_FIRST: begin
                w.op = OP_COMMIT;
                w.status = ST_FIRST;
                w.target = PC_EMIT;
            end
            PC_BACK: begin
                w.op = OP_COMMIT;
                w.status = ST_BACK;
                w.target = PC_EMIT;
            end
            PC_NOTICK: begin
                w.op = OP_COMMIT;
                w.status = ST_NOTICK;
                w.cond = C_NEXT;
            end
            PC_EMIT: begin
                w.op = OP_EMIT;
                w.cond = C_OUTBUSY;
                w.target = PC_EMIT;
            end
            default: begin
                w.cond = C_ALWAYS;
                w.target = PC_WAIT;
            end
        endcase
        return w;
    endfunction

    assign o_cw = ucode(r_pc);

    always_comb begin
        case (o_cw.cond)
            C_NEXT:    take = 1'b0;
            C_ALWAYS:  take = 1'b1;
            C_NOVALID: take = !i_flags.in_valid;
            C_SUMLOOP: take = !i_flags.sum_last;
            C_DIVLOOP: take = !i_flags.div_last;
            C_NOPREV:  take = !i_flags.have_prev;
            C_BAD:     take = i_flags.bad;
            C_ZERO:    take = i_flags.zero;
            C_OUTBUSY: take = i_flags.out_busy;
            default:   take = 1'b1;
        endcase
        n_pc = take ? o_cw.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> src/cud_datapath.sv
`timescale 1ns / 1ps
// Snapshot registers, 64-bit adder, shared radix-2 divider and output register.
module cud_datapath import cud_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_cw                             i_cw,
    input  logic                            i_in_valid,
    input  logic                            i_out_ready,
    input  logic [NUM_CTR-1:0][CTR_W-1:0]   i_ctr,
    output t_flags                          o_flags,
    output logic                            o_out_valid,
    output t_status                         o_status,
    output logic [FRAC_BITS:0]              o_busy,
    output logic [FRAC_BITS:0]              o_user,
    output logic [FRAC_BITS:0]              o_sys,
    output logic [FRAC_BITS:0]              o_iow
);

    localparam int CNT_W = $clog2(FRAC_BITS);
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [NUM_CTR-1:0][CTR_W-1:0] r_cur;
    logic [CTR_W-1:0] r_acc, r_tot_cur, r_idle_cur, r_tdelta, r_idelta;
    logic [CTR_W-1:0] r_prev_tot, r_prev_idle, r_prev_user, r_prev_sys, r_prev_iow;
    logic [CTR_W-1:0] r_rem;
    logic [FRAC_BITS-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic r_sat, r_bad, r_zero, r_have_prev, r_out_valid;
    logic [FRAC_BITS:0] r_busy, r_user, r_sys, r_iow;
    t_status r_status;
    t_status r_o_status;
    logic [FRAC_BITS:0] r_o_busy, r_o_user, r_o_sys, r_o_iow;

    logic             in_accept;
    logic             out_busy;
    logic             emit;
    logic [CTR_W-1:0] n_sum;
    logic [CTR_W:0]   n_tdiff, n_idiff;
    logic [CTR_W-1:0] n_num;
    logic [CTR_W:0]   n_shift, n_trial;
    logic             n_take;
    logic [FRAC_BITS:0] n_res;

    assign in_accept = (i_cw.op == OP_WAIT) && i_in_valid;
    assign out_busy  = r_out_valid && !i_out_ready;
    assign emit      = (i_cw.op == OP_EMIT) && !out_busy;

    assign n_sum   = r_acc + r_cur[r_cnt[IDX_W-1:0]];
    assign n_tdiff = {1'b0, r_acc} - {1'b0, r_prev_tot};
    assign n_idiff = {1'b0, r_acc} - {1'b0, r_prev_idle};

    always_comb begin
        case (i_cw.sel)
            SEL_BUSY: n_num = r_idelta;
            SEL_USER: n_num = r_cur[IDX_USER] - r_prev_user;
            SEL_SYS:  n_num = r_cur[IDX_SYSTEM] - r_prev_sys;
            SEL_IOW:  n_num = r_cur[IDX_IOWAIT] - r_prev_iow;
            default:  n_num = r_idelta;
        endcase
    end

    // The remainder stays below the divisor, so bit 64 of the trial is the borrow.
    assign n_shift = {r_rem, 1'b0};
    assign n_trial = n_shift - {1'b0, r_tdelta};
    assign n_take  = !n_trial[CTR_W];
    assign n_res   = r_sat ? ONE : {1'b0, r_quo};

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cur <= i_ctr;
        end
        case (i_cw.op)
            OP_CLR: begin
                r_acc <= '0;
                r_cnt <= '0;
            end
            OP_ACC: begin
                r_acc <= n_sum;
                r_cnt <= r_cnt + 1'b1;
            end
            OP_TOT: begin
                r_tot_cur <= r_acc;
                r_tdelta  <= n_tdiff[CTR_W-1:0];
                r_bad     <= n_tdiff[CTR_W];
            end
            OP_IDLE: begin
                r_acc <= r_cur[IDX_IDLE] + r_cur[IDX_IOWAIT];
            end
            OP_IDEL: begin
                r_idle_cur <= r_acc;
                r_idelta   <= n_idiff[CTR_W-1:0];
                r_bad      <= r_bad | n_idiff[CTR_W];
                r_zero     <= (r_tdelta == '0);
            end
            OP_DLOAD: begin
                r_rem <= n_num;
                r_quo <= '0;
                r_cnt <= '0;
            end
            OP_DSAT: begin
                r_sat <= (r_rem >= r_tdelta);
            end
            OP_DSTEP: begin
                r_rem <= n_take ? n_trial[CTR_W-1:0] : n_shift[CTR_W-1:0];
                r_quo <= {r_quo[FRAC_BITS-2:0], n_take};
                r_cnt <= r_cnt + 1'b1;
            end
            OP_DSTORE: begin
                case (i_cw.sel)
                    SEL_BUSY: r_busy <= ONE - n_res;
                    SEL_USER: r_user <= n_res;
                    SEL_SYS:  r_sys  <= n_res;
                    SEL_IOW:  r_iow  <= n_res;
                    default:  r_busy <= ONE - n_res;
                endcase
            end
            OP_COMMIT: begin
                r_status    <= i_cw.status;
                r_prev_tot  <= r_tot_cur;
                r_prev_idle <= r_idle_cur;
                r_prev_user <= r_cur[IDX_USER];
                r_prev_sys  <= r_cur[IDX_SYSTEM];
                r_prev_iow  <= r_cur[IDX_IOWAIT];
                if (i_cw.status != ST_OK) begin
                    r_busy <= '0;
                    r_user <= '0;
                    r_sys  <= '0;
                    r_iow  <= '0;
                end
            end
            default: begin
            end
        endcase
        if (emit) begin
            r_o_status <= r_status;
            r_o_busy   <= r_busy;
            r_o_user   <= r_user;
            r_o_sys    <= r_sys;
            r_o_iow    <= r_iow;
        end
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cw.op == OP_COMMIT) begin
                r_have_prev <= 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_flags = '{
        in_valid:  i_in_valid,
        have_prev: r_have_prev,
        bad:       r_bad,
        zero:      r_zero,
        sum_last:  (r_cnt == CNT_W'(NUM_CTR - 1)),
        div_last:  (r_cnt == CNT_W'(FRAC_BITS - 1)),
        out_busy:  out_busy
    };

    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_busy      = r_o_busy;
    assign o_user      = r_o_user;
    assign o_sys       = r_o_sys;
    assign o_iow       = r_o_iow;

endmodule

>>> src/cpu_utilization_delta.sv
`timescale 1ns / 1ps
// Top level of the CPU utilisation block: tick counter snapshots in, busy ratios out.
//
//   Channel   Handshake            Payload
//   input     i_valid / o_ready    eight 64-bit cumulative tick counters
//   output    o_valid / i_ready    status and four Q1.FRAC_BITS ratios
//
// A beat that yields ratios holds off the next input beat while the shared
// bit-per-cycle divider forms the four quotients in turn. A first sample,
// counters that went backwards and a sample with no elapsed ticks skip the
// divider.
// Reset is synchronous and active low; it clears the step counter, the output
// valid and the flag that a previous snapshot is held.
// A result waits in the output register while the next beat is taken; a stalled
// output holds the sequencer only when a second result is ready to leave.
module cpu_utilization_delta import cud_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [CTR_W-1:0]     i_user_ticks,
    input  logic [CTR_W-1:0]     i_nice_ticks,
    input  logic [CTR_W-1:0]     i_system_ticks,
    input  logic [CTR_W-1:0]     i_idle_ticks,
    input  logic [CTR_W-1:0]     i_iowait_ticks,
    input  logic [CTR_W-1:0]     i_irq_ticks,
    input  logic [CTR_W-1:0]     i_softirq_ticks,
    input  logic [CTR_W-1:0]     i_steal_ticks,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_sample_status,
    output logic [FRAC_BITS:0]   o_busy_ratio,
    output logic [FRAC_BITS:0]   o_user_share,
    output logic [FRAC_BITS:0]   o_system_share,
    output logic [FRAC_BITS:0]   o_iowait_share
);

    t_cw                           cw;
    t_flags                        flags;
    t_status                       status;
    logic [NUM_CTR-1:0][CTR_W-1:0] ctr;

    assign ctr = {i_steal_ticks, i_softirq_ticks, i_irq_ticks, i_iowait_ticks,
                  i_idle_ticks, i_system_ticks, i_nice_ticks, i_user_ticks};

    assign o_ready         = i_rst_n && (cw.op == OP_WAIT);
    assign o_sample_status = status;

    cud_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_cw    (cw)
    );

    cud_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cw        (cw),
        .i_in_valid  (i_valid),
        .i_out_ready (i_ready),
        .i_ctr       (ctr),
        .o_flags     (flags),
        .o_out_valid (o_valid),
        .o_status    (status),
        .o_busy      (o_busy_ratio),
        .o_user      (o_user_share),
        .o_sys       (o_system_share),
        .o_iow       (o_iowait_share)
    );

endmodule

>>> src/cud_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the CPU utilisation block and their binding to the top level.
module cud_checker import cud_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [1:0]         o_sample_status,
    input logic [FRAC_BITS:0] o_busy_ratio,
    input logic [FRAC_BITS:0] o_user_share,
    input logic [FRAC_BITS:0] o_system_share,
    input logic [FRAC_BITS:0] o_iowait_share
);

    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // A stalled result beat keeps its status, busy ratio and user share.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample_status)
            && $stable(o_busy_ratio) && $stable(o_user_share))
        else $error("stalled result beat changed");

    // A discarded sample carries zero ratios.
    a_zero_ratios: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_sample_status != ST_OK) |-> (o_busy_ratio == '0)
            && (o_user_share == '0) && (o_system_share == '0) && (o_iowait_share == '0))
        else $error("ratios not zero on a discarded sample");

    // No ratio exceeds one.
    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_busy_ratio <= ONE) && (o_user_share <= ONE)
            && (o_system_share <= ONE) && (o_iowait_share <= ONE))
        else $error("ratio above one");

    // The sequencer is busy in the cycle after it takes an input beat.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken again straight after a beat");

endmodule

bind cpu_utilization_delta cud_checker #(.FRAC_BITS(FRAC_BITS)) u_cud_checker (.*);
